### src/nvr_pkg.sv
// Shared types, codes and the access table for the record sync sequencer.
// No dependencies; nvr_seq and the top-level sequencer import this package.
`default_nettype none

package nvr_pkg;

  localparam int NUM_RECORDS_DEF = 3;
  localparam int ROM_BYTES_DEF   = 21;
  localparam int CNT_W           = 8;   // byte counter, wraps like the chip firmware
  localparam int PTR_W           = 8;   // chip address pointer, same
  localparam logic [7:0] MASK_RESET = 8'h0C;

  // latch bits
  localparam logic [7:0] LAT_CLK = 8'h01;
  localparam logic [7:0] LAT_C2  = 8'h02;
  localparam logic [7:0] LAT_C1  = 8'h04;
  localparam logic [7:0] LAT_SEL = 8'h08;

  localparam logic [CNT_W-1:0] SLOTS_PER_REC = CNT_W'(6);

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_START_RD = 3'd1,
    REQ_START_UPD = 3'd2,
    REQ_ERASE_ALL = 3'd3,
    REQ_TBL_WR = 3'd4,
    REQ_TBL_RD = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ERASE = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_ADDR  = 2'd1,
    ACC_REPLY = 2'd2
  } acc_kind_t;

  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_IDLE,
    JOB_ERASE,
    JOB_WRITE,
    JOB_READ,
    JOB_TREAD
  } job_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_CLEAR,
    SQ_FETCH,
    SQ_EMIT
  } seq_state_t;

  typedef struct packed {
    acc_kind_t   kind;
    logic [4:0]  addr;
    logic [7:0]  data;
  } acc_t;

  typedef struct packed {
    acc_kind_t   access_kind;
    logic [4:0]  chip_address;
    logic [7:0]  data_value;
    mode_t       mode_now;
    logic [7:0]  bad_records;
    logic        last_of_run;
  } out_item_t;

  // number of items a job emits
  function automatic logic [2:0] job_len(job_t j);
    logic [2:0] n;
    unique case (j)
      JOB_NONE:  n = 3'd0;
      JOB_IDLE:  n = 3'd1;
      JOB_ERASE: n = 3'd3;
      JOB_WRITE: n = 3'd3;
      JOB_READ:  n = 3'd6;
      JOB_TREAD: n = 3'd1;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // k-th access of a job; a = chip address, v = data byte for write/reply
  function automatic acc_t access_of(job_t j, logic [2:0] k, logic [4:0] a, logic [7:0] v);
    acc_t r;
    r = '{kind: ACC_LATCH, addr: 5'd0, data: 8'd0};
    unique case (j)
      JOB_ERASE: begin
        unique case (k)
          3'd0:    r.data = LAT_C1 | LAT_C2;
          3'd1:    r = '{kind: ACC_ADDR, addr: a, data: LAT_C1 | LAT_C2};
          default: r.data = LAT_C1 | LAT_C2 | LAT_SEL;
        endcase
      end
      JOB_WRITE: begin
        unique case (k)
          3'd0:    r = '{kind: ACC_ADDR, addr: a, data: v};
          3'd1:    r.data = LAT_C1;
          default: r.data = LAT_C1 | LAT_SEL;
        endcase
      end
      JOB_READ: begin
        unique case (k)
          3'd0:    r = '{kind: ACC_ADDR, addr: a, data: LAT_SEL};
          3'd1:    r.data = LAT_SEL;
          3'd2:    r.data = LAT_SEL | LAT_CLK;
          3'd3:    r.data = LAT_SEL;
          default: r.data = 8'd0;
        endcase
      end
      JOB_TREAD: r = '{kind: ACC_REPLY, addr: 5'd0, data: v};
      default:   r.data = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/nvr_table_ram.sv
// Record table storage: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on nothing but its parameter.
`default_nettype none

module nvr_table_ram #(
  parameter int DEPTH = 18,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata_r
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : 8'd0;
    end
  end

endmodule

`default_nettype wire

### src/nvr_seq.sv
// Step sequencer: mode/pointer/checksum state, table read-modify-write
// and the access stream. Uses nvr_pkg and instantiates nvr_table_ram.
`default_nettype none

module nvr_seq
  import nvr_pkg::*;
#(
  parameter int NUM_RECORDS = NUM_RECORDS_DEF,
  parameter int ROM_BYTES   = ROM_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] gate_mask,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_tick_count,
  input  wire logic [7:0] in_rom_data,
  input  wire logic [1:0] in_first_changed_record,
  input  wire logic [4:0] in_table_index,
  input  wire logic [7:0] in_table_value,
  output logic            ev_valid,
  input  wire logic       ev_ready,
  output out_item_t       ev
);

  localparam int TABLE_BYTES = 6 * NUM_RECORDS;
  localparam int INIT_BASE   = 3 * NUM_RECORDS;
  localparam int TA_W        = $clog2(TABLE_BYTES);
  localparam int BASE_W      = $clog2(3 * (ROM_BYTES / 7) + 16);
  localparam int SW          = $clog2(TABLE_BYTES + 2 ** BASE_W + 3);

  seq_state_t        state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [7:0]        cs_r, cs_nxt;
  logic [7:0]        bad_r, bad_nxt;
  job_t              job_r, job_nxt;
  logic [4:0]        addr_r, addr_nxt;
  logic [7:0]        val_r, val_nxt;
  logic              zero_r, zero_nxt;
  logic              use_ram_r, use_ram_nxt;
  logic              add_cs_r, add_cs_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [2:0]        clr_k_r, clr_k_nxt;
  logic              need_clr;

  logic              ram_we, ram_re;
  logic [TA_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic [SW-1:0]     step_slot, clr_slot;
  logic              step_ok, clr_ok, tidx_ok;
  logic [7:0]        fetch_v;
  logic [PTR_W:0]    ptr_inc;
  logic [CNT_W-1:0]  cnt_dec;
  acc_t              acc;
  logic [2:0]        len;

  // table slot k (0..5) of the record at base b
  function automatic logic [SW-1:0] slot_of(logic [2:0] k, logic [BASE_W-1:0] b);
    logic [SW-1:0] ext;
    ext = SW'(b);
    if (k < 3'd3) begin
      return ext + SW'(k);
    end
    return ext + SW'(INIT_BASE) + SW'(k) - SW'(3);
  endfunction

  nvr_table_ram #(.DEPTH(TABLE_BYTES)) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign step_slot = slot_of(cnt_r[2:0], base_r);
  assign step_ok   = step_slot < SW'(TABLE_BYTES);
  assign clr_slot  = slot_of(clr_k_r, base_r);
  assign clr_ok    = clr_slot < SW'(TABLE_BYTES);
  assign tidx_ok   = 6'(in_table_index) < 6'(TABLE_BYTES);
  assign fetch_v   = zero_r ? 8'd0 : ram_rdata;
  assign ptr_inc   = (PTR_W + 1)'(ptr_r) + (PTR_W + 1)'(1);
  assign cnt_dec   = cnt_r - CNT_W'(1);

  // datapath next values and table port
  always_comb begin
    mode_nxt    = mode_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    base_nxt    = base_r;
    cs_nxt      = cs_r;
    bad_nxt     = bad_r;
    job_nxt     = job_r;
    addr_nxt    = addr_r;
    val_nxt     = val_r;
    zero_nxt    = zero_r;
    use_ram_nxt = use_ram_r;
    add_cs_nxt  = add_cs_r;
    k_nxt       = k_r;
    clr_k_nxt   = clr_k_r;
    need_clr    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = 8'd0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          job_nxt     = JOB_NONE;
          addr_nxt    = ptr_r[4:0];
          zero_nxt    = 1'b0;
          use_ram_nxt = 1'b0;
          add_cs_nxt  = 1'b0;
          k_nxt       = 3'd0;
          clr_k_nxt   = 3'd0;
          unique case (req_t'(in_req_type))
            REQ_TICK: begin
              if ((in_tick_count & gate_mask) == 8'd0) begin
                unique case (mode_r)
                  MODE_IDLE: job_nxt = JOB_IDLE;
                  MODE_ERASE: begin
                    job_nxt = JOB_ERASE;
                    cnt_nxt = cnt_dec;
                    if (cnt_dec == '0) begin
                      mode_nxt = MODE_WRITE;      // pointer lands back on the start
                    end else begin
                      ptr_nxt = ptr_r - PTR_W'(1);
                    end
                  end
                  MODE_WRITE: begin
                    job_nxt = JOB_WRITE;
                    if (cnt_r >= SLOTS_PER_REC) begin
                      cnt_nxt  = '0;
                      base_nxt = base_r + BASE_W'(3);
                      val_nxt  = cs_r;            // checksum byte
                    end else begin
                      if (cnt_r == '0) begin
                        cs_nxt = 8'd0;
                      end
                      ram_re      = step_ok;
                      ram_raddr   = step_slot[TA_W-1:0];
                      zero_nxt    = !step_ok;
                      use_ram_nxt = 1'b1;
                      add_cs_nxt  = 1'b1;
                      cnt_nxt     = cnt_r + CNT_W'(1);
                    end
                    if (ptr_inc < (PTR_W + 1)'(ROM_BYTES)) begin
                      ptr_nxt = ptr_inc[PTR_W-1:0];
                    end else begin
                      mode_nxt = MODE_IDLE;
                    end
                  end
                  MODE_READ: begin
                    job_nxt = JOB_READ;
                    if (cnt_r >= SLOTS_PER_REC) begin
                      cnt_nxt = '0;
                      if (in_rom_data != cs_r) begin
                        need_clr = 1'b1;
                        if (bad_r != 8'hFF) begin
                          bad_nxt = bad_r + 8'd1;
                        end
                      end else begin
                        base_nxt = base_r + BASE_W'(3);
                      end
                    end else begin
                      ram_we    = step_ok;
                      ram_waddr = step_slot[TA_W-1:0];
                      ram_wdata = in_rom_data;
                      cs_nxt    = ((cnt_r == '0) ? 8'd0 : cs_r) + in_rom_data;
                      cnt_nxt   = cnt_r + CNT_W'(1);
                    end
                    if (ptr_inc < (PTR_W + 1)'(ROM_BYTES)) begin
                      ptr_nxt = ptr_inc[PTR_W-1:0];
                    end else begin
                      mode_nxt = MODE_IDLE;
                    end
                  end
                  default: job_nxt = JOB_NONE;
                endcase
              end
            end
            REQ_START_RD: begin
              if (mode_r != MODE_ERASE) begin
                cnt_nxt  = '0;
                ptr_nxt  = '0;
                base_nxt = '0;
                mode_nxt = MODE_READ;
              end
            end
            REQ_START_UPD: begin
              if (mode_r == MODE_IDLE &&
                  4'(in_first_changed_record) < 4'(NUM_RECORDS)) begin
                mode_nxt = MODE_ERASE;
                ptr_nxt  = PTR_W'(ROM_BYTES - 1);
                if (bad_r != 8'd0) begin
                  cnt_nxt  = CNT_W'(ROM_BYTES);
                  base_nxt = '0;
                  bad_nxt  = 8'd0;
                end else begin
                  cnt_nxt  = CNT_W'(ROM_BYTES) - CNT_W'(8'd7 * 8'(in_first_changed_record));
                  base_nxt = BASE_W'(4'(in_first_changed_record) +
                                     {1'b0, in_first_changed_record, 1'b0});
                end
              end
            end
            REQ_ERASE_ALL: begin
              mode_nxt = MODE_ERASE;
              cnt_nxt  = CNT_W'(ROM_BYTES);
              ptr_nxt  = PTR_W'(ROM_BYTES - 1);
              base_nxt = '0;
              bad_nxt  = 8'd0;
            end
            REQ_TBL_WR: begin
              ram_we    = tidx_ok;
              ram_waddr = TA_W'(in_table_index);
              ram_wdata = in_table_value;
            end
            REQ_TBL_RD: begin
              job_nxt     = JOB_TREAD;
              ram_re      = tidx_ok;
              ram_raddr   = TA_W'(in_table_index);
              zero_nxt    = !tidx_ok;
              use_ram_nxt = 1'b1;
            end
            default: job_nxt = JOB_NONE;
          endcase
        end
      end
      SQ_CLEAR: begin
        // zero the failed record, one slot a cycle
        ram_we    = clr_ok;
        ram_waddr = clr_slot[TA_W-1:0];
        ram_wdata = 8'd0;
        clr_k_nxt = clr_k_r + 3'd1;
      end
      SQ_FETCH: begin
        if (use_ram_r) begin
          val_nxt = fetch_v;
          if (add_cs_r) begin
            cs_nxt = cs_r + fetch_v;
          end
        end
      end
      SQ_EMIT: begin
        if (ev_ready) begin
          k_nxt = k_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign len = job_len(job_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          if (need_clr) begin
            state_nxt = SQ_CLEAR;
          end else if (job_nxt == JOB_NONE) begin
            state_nxt = SQ_IDLE;
          end else begin
            state_nxt = SQ_FETCH;
          end
        end
      end
      SQ_CLEAR: begin
        if (clr_k_r == 3'd5) begin
          state_nxt = SQ_FETCH;
        end
      end
      SQ_FETCH: state_nxt = SQ_EMIT;
      SQ_EMIT: begin
        if (ev_ready && k_r == len - 3'd1) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == SQ_IDLE);
    ev_valid = (state_r == SQ_EMIT);
    acc      = access_of(job_r, k_r, addr_r, val_r);
    ev       = '{access_kind:  acc.kind,
                 chip_address: acc.addr,
                 data_value:   acc.data,
                 mode_now:     mode_r,
                 bad_records:  bad_r,
                 last_of_run:  (k_r == len - 3'd1)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      mode_r  <= MODE_IDLE;
      ptr_r   <= '0;
      cnt_r   <= '0;
      base_r  <= '0;
      cs_r    <= 8'd0;
      bad_r   <= 8'd0;
      job_r   <= JOB_NONE;
      k_r     <= 3'd0;
      clr_k_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      cs_r    <= cs_nxt;
      bad_r   <= bad_nxt;
      job_r   <= job_nxt;
      k_r     <= k_nxt;
      clr_k_r <= clr_k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    val_r     <= val_nxt;
    zero_r    <= zero_nxt;
    use_ram_r <= use_ram_nxt;
    add_cs_r  <= add_cs_nxt;
  end

endmodule

`default_nettype wire

### src/nvr_record_sync_sequencer.sv
// Record sync sequencer: mirrors NUM_RECORDS seven-byte records (three score
// bytes, three initials, checksum) between a RAM table and a slow nonvolatile
// chip of ROM_BYTES bytes. Only a tick whose counter ANDed with the gate mask
// (cfg port, reset 0x0C) is zero steps the machine; each step emits its chip
// accesses as out items, the last one flagged with out_last_of_run. An item
// that emits n accesses (n is 1 for an idle step or table read, 3 for
// erase/write, 6 for read) passes a fetch state for the registered read port
// of the table RAM before its accesses go out, each held while the output
// stalls. A read step that finds a bad checksum first zeroes the record's six
// table slots, one table write per cycle. Start commands and table writes
// emit nothing. The next item is taken while the last access still waits in
// the output register. The cfg port is always ready; write it only while idle.
// Depends on nvr_pkg and nvr_seq (which holds the table RAM).
`default_nettype none

module nvram_record_sync_sequencer
  import nvr_pkg::*;
#(
  parameter int NUM_RECORDS = NUM_RECORDS_DEF,
  parameter int ROM_BYTES   = ROM_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // gate mask write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  // request items
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_tick_count,
  input  wire logic [7:0] in_rom_data,
  input  wire logic [1:0] in_first_changed_record,
  input  wire logic [4:0] in_table_index,
  input  wire logic [7:0] in_table_value,
  // chip access items
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_access_kind,
  output logic [4:0]      out_chip_address,
  output logic [7:0]      out_data_value,
  output logic [1:0]      out_mode_now,
  output logic [7:0]      out_bad_records,
  output logic            out_last_of_run
);

  logic [7:0] mask_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       ev_valid, ev_ready;
  out_item_t  ev;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_valid) begin
      mask_r <= cfg_data;
    end
  end

  nvr_seq #(
    .NUM_RECORDS (NUM_RECORDS),
    .ROM_BYTES   (ROM_BYTES)
  ) u_seq (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .gate_mask               (mask_r),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_req_type             (in_req_type),
    .in_tick_count           (in_tick_count),
    .in_rom_data             (in_rom_data),
    .in_first_changed_record (in_first_changed_record),
    .in_table_index          (in_table_index),
    .in_table_value          (in_table_value),
    .ev_valid                (ev_valid),
    .ev_ready                (ev_ready),
    .ev                      (ev)
  );

  // Output register: loads whenever it is empty or being drained.
  assign ev_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ev_ready) begin
      out_valid_r <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev_valid) begin
      out_item_r <= ev;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_access_kind  = out_item_r.access_kind;
  assign out_chip_address = out_item_r.chip_address;
  assign out_data_value   = out_item_r.data_value;
  assign out_mode_now     = out_item_r.mode_now;
  assign out_bad_records  = out_item_r.bad_records;
  assign out_last_of_run  = out_item_r.last_of_run;

endmodule

`default_nettype wire
